>>> rtl/fifo_page_replacement_core_macros.svh
// ---------------------------------------------------------------------------
// FIFO page replacement core - assertion macros
// Implication checks on the rising clock edge, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef FIFO_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define FPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fpr: same-cycle check failed");
// next-cycle implication
`define FPR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fpr: next-cycle check failed");
`else
`define FPR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FPR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/fpr_pkg.sv
// ---------------------------------------------------------------------------
// FIFO page replacement package
// Shared constants and the controller-to-datapath command type.
// ---------------------------------------------------------------------------
package fpr_pkg;

  // default sizing
  localparam int FramesDef   = 16;
  localparam int PageBitsDef = 16;

  // register and counter widths
  localparam int CfgW   = 5;
  localparam int CountW = 32;

  localparam logic [CfgW-1:0]   ResidentSizeRst = 5'd4;
  localparam logic [CountW-1:0] CountMax        = {CountW{1'b1}};

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming page number
    logic execute;  // look up, update frames and counts, load result
  } cmd_t;

endpackage

>>> rtl/fifo_page_replacement_core.sv
// ---------------------------------------------------------------------------
// FIFO page replacement core
// Top level: controller and datapath, plus interface checks.
// ---------------------------------------------------------------------------
// Each accepted page access gives one result: hit flag, evicted page (if
// any) and the saturating hit and fault totals after that access. One
// access is handled at a time, in order: the page is taken, then the
// parallel compare over all frames and the frame update run, then the
// result is presented and held while the output is stalled. The
// resident size register may be written at any time the block is idle;
// zero acts as one and values above FRAMES act as FRAMES. Occupancy bits
// clear at reset, so no clearing pass is needed.
`include "fifo_page_replacement_core_macros.svh"

module fifo_page_replacement_core #(
  parameter int FRAMES    = fpr_pkg::FramesDef,
  parameter int PAGE_BITS = fpr_pkg::PageBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fpr_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [PAGE_BITS-1:0]       page_number_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o,
  output logic                       evicted_valid_o,
  output logic [PAGE_BITS-1:0]       evicted_page_o,
  output logic [fpr_pkg::CountW-1:0] hit_total_o,
  output logic [fpr_pkg::CountW-1:0] miss_total_o
);
  import fpr_pkg::*;

  cmd_t cmd;

  fpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  fpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .page_number_i   (page_number_i),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o)
  );

  // an eviction only happens on a fault
  `FPR_ASSERT_IMP(a_evict_on_fault, clk_i, rst_ni, out_valid_o && evicted_valid_o, !hit_o)
  // evicted page reads zero when nothing was evicted
  `FPR_ASSERT_IMP(a_evp_zero, clk_i, rst_ni, out_valid_o && !evicted_valid_o, evicted_page_o == '0)
  // an input transfer makes the block busy
  `FPR_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // exactly one result per access
  `FPR_ASSERT_NXT(a_one_result, clk_i, rst_ni, out_valid_o && !out_stall_i, !out_valid_o)

endmodule

>>> rtl/fpr_ctrl.sv
// ---------------------------------------------------------------------------
// FIFO page replacement controller
// Sequences one access at a time: capture, execute, present result.
// ---------------------------------------------------------------------------
module fpr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fpr_pkg::cmd_t cmd_o
);
  import fpr_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec: begin
        state_d = StDone;
      end
      StDone: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // handshake and commands
  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = (state_q == StDone);
  assign cmd_o.capture = in_valid_i && (state_q == StIdle);
  assign cmd_o.execute = (state_q == StExec);

endmodule

>>> rtl/fpr_datapath.sv
// ---------------------------------------------------------------------------
// FIFO page replacement datapath
// Frame store with parallel compare, oldest pointer, fill count, counters.
// ---------------------------------------------------------------------------
module fpr_datapath #(
  parameter int FRAMES    = fpr_pkg::FramesDef,
  parameter int PAGE_BITS = fpr_pkg::PageBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fpr_pkg::cmd_t             cmd_i,
  input  logic                      cfg_we_i,
  input  logic [fpr_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic [PAGE_BITS-1:0]      page_number_i,
  output logic                      hit_o,
  output logic                      evicted_valid_o,
  output logic [PAGE_BITS-1:0]      evicted_page_o,
  output logic [fpr_pkg::CountW-1:0] hit_total_o,
  output logic [fpr_pkg::CountW-1:0] miss_total_o
);
  import fpr_pkg::*;

  localparam int PtrW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FillW = $clog2(FRAMES + 1);
  localparam int SumW  = ((PtrW > FillW) ? PtrW : FillW) + 1;

  logic [CfgW-1:0]      size_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [PAGE_BITS-1:0] frame_q [FRAMES];
  logic [FRAMES-1:0]    valid_q, valid_d;
  logic [PtrW-1:0]      oldest_q;
  logic [FillW-1:0]     fill_q;
  logic [CountW-1:0]    hit_cnt_q, miss_cnt_q;
  logic                 hit_q, ev_q;
  logic [PAGE_BITS-1:0] evp_q;

  logic [FRAMES-1:0]    match;
  logic                 found, evict;
  logic [FillW-1:0]     eff_size, fill_m;
  logic [PtrW-1:0]      oldest_inc, base, tail;
  logic [SumW-1:0]      tail_sum;
  logic [PAGE_BITS-1:0] victim;

  // resident size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= ResidentSizeRst;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // incoming page
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) page_q <= page_number_i;
  end

  // size clamped to 1..FRAMES
  always_comb begin
    if (size_q == '0) begin
      eff_size = FillW'(1);
    end else if (int'(size_q) > FRAMES) begin
      eff_size = FillW'(FRAMES);
    end else begin
      eff_size = FillW'(size_q);
    end
  end

  // fully associative compare over the resident frames
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = valid_q[i] && (frame_q[i] == page_q);
    end
  end

  assign found  = |match;
  assign evict  = !found && (fill_q >= eff_size);
  assign victim = frame_q[oldest_q];

  // pointer arithmetic, wrapping at FRAMES
  assign oldest_inc = (oldest_q == PtrW'(FRAMES - 1)) ? '0 : oldest_q + PtrW'(1);
  assign base       = evict ? oldest_inc : oldest_q;
  assign fill_m     = fill_q - FillW'(evict);
  assign tail_sum   = SumW'(base) + SumW'(fill_m);
  assign tail       = (tail_sum >= SumW'(FRAMES)) ? PtrW'(tail_sum - SumW'(FRAMES))
                                                  : PtrW'(tail_sum);

  // frame contents, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && !found) frame_q[tail] <= page_q;
  end

  // next occupancy: clear the evicted slot, then mark the tail
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.execute && !found) begin
      if (evict) valid_d[oldest_q] = 1'b0;
      // set after clear: tail may be the slot just vacated
      valid_d[tail] = 1'b1;
    end
  end

  // occupancy, pointer and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      oldest_q   <= '0;
      fill_q     <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.execute) begin
        if (found) begin
          if (hit_cnt_q != CountMax) hit_cnt_q <= hit_cnt_q + CountW'(1);
        end else begin
          if (evict) oldest_q <= oldest_inc;
          fill_q <= fill_m + FillW'(1);
          if (miss_cnt_q != CountMax) miss_cnt_q <= miss_cnt_q + CountW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      hit_q <= found;
      ev_q  <= evict;
      evp_q <= evict ? victim : '0;
    end
  end

  assign hit_o           = hit_q;
  assign evicted_valid_o = ev_q;
  assign evicted_page_o  = evp_q;
  assign hit_total_o     = hit_cnt_q;
  assign miss_total_o    = miss_cnt_q;

endmodule
